// ----- rtl/bdq_pkg.sv -----
// shared types and codes for the bounded deque
package bdq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned DATA_W        = 64;
  localparam int unsigned REQ_W         = 3;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned COUNT_W_DEFAULT = $clog2(DEPTH_DEFAULT + 1);

  localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_REVERSE    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // one request handed to the ring for its update cycle
  typedef struct packed {
    logic              en;
    logic [REQ_W-1:0]  req;
    logic [DATA_W-1:0] data;
  } upd_t;

  // ring status seen by the control logic
  typedef struct packed {
    logic empty;
    logic full;
    logic reversed;
  } view_t;

endpackage

// ----- rtl/bdq_if.sv -----
// request and response channel interfaces of the bounded deque
interface bdq_req_if;
  import bdq_pkg::*;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [DATA_W-1:0] data_value;

  modport source (output valid, output req_type, output data_value, input ready);
  modport sink   (input valid, input req_type, input data_value, output ready);
endinterface

interface bdq_rsp_if #(
  parameter int unsigned CountW = bdq_pkg::COUNT_W_DEFAULT
);
  import bdq_pkg::*;
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   front_value;
  logic [DATA_W-1:0]   back_value;
  logic [CountW-1:0]   entry_count;
  logic                is_empty;
  logic                is_full;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output front_value, output back_value, output entry_count,
                  output is_empty, output is_full, output status, input ready);
  modport sink   (input valid, input front_value, input back_value, input entry_count,
                  input is_empty, input is_full, input status, output ready);
endinterface

// ----- rtl/bounded_deque_with_reverse_unit.sv -----
// top level of the bounded double-ended queue with reversal
//
// usage:
//   req_i carries one request per transfer: req_type selects query, push front,
//   push back, pop front, pop back or reverse; data_value is the value to push.
//   rsp_o returns exactly one result per request: front and back values after
//   the step (zero when empty), entry count, empty and full flags, and status
//   (ok, pop on empty ignored, push on full dropped).
// sequence:
//   a request runs in three steps: update of the ring and memory write, then
//   the two-port memory read of both ends, then the response register load.
//   one request is in flight at a time, so a new request is accepted only after
//   the previous one has passed the read of the ends and the response load.
// reset:
//   head, count and reversed flag clear, the queue is empty; memory contents
//   are not cleared, entries are read only after they are written.
// stall:
//   the response sits in its output register until taken; a new request is
//   accepted once that register is empty or is being drained in the same cycle.
module bounded_deque_with_reverse_unit
  import bdq_pkg::*;
#(
  parameter int unsigned Depth = DEPTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bdq_req_if.sink   req_i,
  bdq_rsp_if.source rsp_o
);

  localparam int unsigned CountW = $clog2(Depth + 1);

  // one-hot sequencer: update, read both ends, respond
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;

  upd_t              upd;
  view_t             view;
  logic [CountW-1:0] ring_count;
  logic [DATA_W-1:0] low_val, high_val;
  logic              accept;
  logic              is_push, is_pop;

  logic [STATUS_W-1:0] status_q, status_d;
  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   front_q, back_q;
  logic [CountW-1:0]   count_out_q;
  logic                empty_q, full_q;

  assign req_i.ready = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  assign upd = '{en: accept, req: req_i.req_type, data: req_i.data_value};

  bdq_ring #(
    .Depth  (Depth),
    .CountW (CountW)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (upd),
    .rd_en_i (state_q == S_READ),
    .view_o  (view),
    .count_o (ring_count),
    .low_o   (low_val),
    .high_o  (high_val)
  );

  // status judged against the state before the update
  assign is_push = (req_i.req_type == REQ_PUSH_FRONT) || (req_i.req_type == REQ_PUSH_BACK);
  assign is_pop  = (req_i.req_type == REQ_POP_FRONT) || (req_i.req_type == REQ_POP_BACK);

  always_comb begin
    status_d = status_q;
    if (accept) begin
      if (is_push && view.full) begin
        status_d = ST_FULL;
      end else if (is_pop && view.empty) begin
        status_d = ST_EMPTY;
      end else begin
        status_d = ST_OK;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_READ;
      S_READ: state_d = S_RESP;
      S_RESP: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (state_q == S_RESP) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, loaded when the read data of both ends is back; status loads on acceptance
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    if (state_q == S_RESP) begin
      front_q     <= view.empty ? '0 : (view.reversed ? high_val : low_val);
      back_q      <= view.empty ? '0 : (view.reversed ? low_val : high_val);
      count_out_q <= ring_count;
      empty_q     <= view.empty;
      full_q      <= view.full;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.front_value = front_q;
  assign rsp_o.back_value  = back_q;
  assign rsp_o.entry_count = count_out_q;
  assign rsp_o.is_empty    = empty_q;
  assign rsp_o.is_full     = full_q;
  assign rsp_o.status      = status_q;

endmodule

// ----- rtl/bdq_ring.sv -----
// ring storage with head, count and reversed flag, two registered read ports
module bdq_ring
  import bdq_pkg::*;
#(
  parameter int unsigned Depth  = DEPTH_DEFAULT,
  parameter int unsigned CountW = $clog2(Depth + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  upd_t              upd_i,
  input  logic              rd_en_i,
  output view_t             view_o,
  output logic [CountW-1:0] count_o,
  output logic [DATA_W-1:0] low_o,
  output logic [DATA_W-1:0] high_o
);

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned SumW  = AddrW + 1;
  localparam logic [AddrW-1:0]  LastSlot = AddrW'(Depth - 1);
  localparam logic [SumW-1:0]   DepthS   = SumW'(Depth);
  localparam logic [CountW-1:0] DepthC   = CountW'(Depth);

  logic [DATA_W-1:0] mem [Depth];

  logic [AddrW-1:0]  head_q, head_d;
  logic [CountW-1:0] count_q, count_d;
  logic              rev_q, rev_d;
  logic [DATA_W-1:0] low_q, high_q;

  logic [AddrW-1:0]  head_dec, head_inc, tail_slot, last_slot;
  logic [SumW-1:0]   tail_sum, last_sum;
  logic [CountW-1:0] count_m1;
  logic              full, empty;
  logic              put_low, put_high, drop_low, drop_high;
  logic              we;
  logic [AddrW-1:0]  waddr;

  assign full     = (count_q == DepthC);
  assign empty    = (count_q == '0);
  assign count_m1 = count_q - CountW'(1);

  // modular ring arithmetic, valid for any depth of two or more
  assign head_dec  = (head_q == '0) ? LastSlot : head_q - AddrW'(1);
  assign head_inc  = (head_q == LastSlot) ? '0 : head_q + AddrW'(1);
  assign tail_sum  = SumW'(head_q) + SumW'(count_q);
  assign tail_slot = (tail_sum >= DepthS) ? AddrW'(tail_sum - DepthS) : AddrW'(tail_sum);
  assign last_sum  = SumW'(head_q) + SumW'(count_m1);
  assign last_slot = (last_sum >= DepthS) ? AddrW'(last_sum - DepthS) : AddrW'(last_sum);

  always_comb begin
    put_low   = 1'b0;
    put_high  = 1'b0;
    drop_low  = 1'b0;
    drop_high = 1'b0;
    rev_d     = rev_q;
    if (upd_i.en) begin
      case (upd_i.req)
        REQ_PUSH_FRONT: begin
          put_high = !full && rev_q;
          put_low  = !full && !rev_q;
        end
        REQ_PUSH_BACK: begin
          put_low  = !full && rev_q;
          put_high = !full && !rev_q;
        end
        REQ_POP_FRONT: begin
          drop_high = !empty && rev_q;
          drop_low  = !empty && !rev_q;
        end
        REQ_POP_BACK: begin
          drop_low  = !empty && rev_q;
          drop_high = !empty && !rev_q;
        end
        REQ_REVERSE: rev_d = !rev_q;
        default: ;
      endcase
    end
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (put_low) begin
      head_d  = head_dec;
      count_d = count_q + CountW'(1);
    end else if (put_high) begin
      count_d = count_q + CountW'(1);
    end else if (drop_low) begin
      head_d  = head_inc;
      count_d = count_m1;
    end else if (drop_high) begin
      count_d = count_m1;
    end
  end

  assign we    = put_low || put_high;
  assign waddr = put_low ? head_dec : tail_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      rev_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      rev_q   <= rev_d;
    end
  end

  // write in the update cycle, reads only in a later cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= upd_i.data;
    end
    if (rd_en_i) begin
      low_q  <= mem[head_q];
      high_q <= mem[last_slot];
    end
  end

  assign view_o  = '{empty: empty, full: full, reversed: rev_q};
  assign count_o = count_q;
  assign low_o   = low_q;
  assign high_o  = high_q;

endmodule
